// File: src/mdsd_pkg.sv
// Shared types and codes for the motor drive slew and dead band block.
package mdsd_pkg;

	localparam int unsigned PowerW = 16;
	localparam int unsigned MagW   = 15;
	localparam int unsigned CmdW   = 2;
	localparam int unsigned ModeW  = 2;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CmdW-1:0] CMD_SET   = 2'd0;
	localparam logic [CmdW-1:0] CMD_STOP  = 2'd1;
	localparam logic [CmdW-1:0] CMD_ESTOP = 2'd2;

	localparam logic [ModeW-1:0] MODE_IDLE  = 2'd0;
	localparam logic [ModeW-1:0] MODE_RUN   = 2'd1;
	localparam logic [ModeW-1:0] MODE_ERROR = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_POWER_LIMIT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SLEW_STEP   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_DEAD_BAND   = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_INVERT_SIGN = 2'd3;

	localparam logic [MagW-1:0] POWER_LIMIT_RST = 15'h7fff;

	typedef struct packed {
		logic [MagW-1:0] power_limit;
		logic [MagW-1:0] slew_step;
		logic [MagW-1:0] dead_band;
		logic            invert_sign;
	} cfg_t;

endpackage

// File: src/mdsd_shaper.sv
// Power shaping datapath: clamp, slew limit, dead band and sign inversion.
module mdsd_shaper (
	input  mdsd_pkg::cfg_t             cfg,
	input  logic signed [15:0]         request,
	input  logic signed [15:0]         last_power,
	output logic signed [15:0]         shaped,
	output logic signed [15:0]         applied
);
	import mdsd_pkg::*;

	logic signed [16:0] req17;
	logic signed [16:0] lim17;
	logic signed [16:0] clamped;
	logic signed [17:0] last18;
	logic signed [17:0] step18;
	logic signed [17:0] delta;
	logic signed [17:0] slewed;
	logic signed [16:0] slew17;
	logic signed [16:0] dead17;

	always_comb begin
		req17 = {request[15], request};
		lim17 = $signed({2'b00, cfg.power_limit});
		if (req17 > lim17) begin
			clamped = lim17;
		end else if (req17 < -lim17) begin
			clamped = -lim17;
		end else begin
			clamped = req17;
		end

		// The slew history is held before inversion.
		last18 = {{2{last_power[15]}}, last_power};
		step18 = $signed({3'b000, cfg.slew_step});
		delta  = {clamped[16], clamped} - last18;
		slewed = {clamped[16], clamped};
		if (cfg.slew_step != '0) begin
			if (delta > step18) begin
				slewed = last18 + step18;
			end else if (delta < -step18) begin
				slewed = last18 - step18;
			end
		end

		slew17 = slewed[16:0];
		dead17 = $signed({2'b00, cfg.dead_band});
		if (slew17 > -dead17 && slew17 < dead17) begin
			shaped = '0;
		end else begin
			shaped = slew17[15:0];
		end

		applied = cfg.invert_sign ? -shaped : shaped;
	end

endmodule

// File: src/mdsd_core.sv
// Drive state registers, command decode and the result register.
module mdsd_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mdsd_pkg::cfg_t         cfg,
	input  logic                   item_valid,
	input  logic [1:0]             item_command,
	input  logic signed [15:0]     item_request,
	output logic                   advance,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   status,
	output logic signed [15:0]     drive_power,
	output logic [1:0]             run_state,
	output logic                   heading
);
	import mdsd_pkg::*;

	logic signed [15:0] last_q;
	logic signed [15:0] applied_q;
	logic [ModeW-1:0]   mode_q;
	logic               dir_q;
	logic               latch_q;

	logic signed [15:0] last_d;
	logic signed [15:0] applied_d;
	logic [ModeW-1:0]   mode_d;
	logic               dir_d;
	logic               latch_d;
	logic               status_d;

	logic signed [15:0] shaped;
	logic signed [15:0] shaped_applied;

	logic               valid_q;
	logic               status_q;
	logic signed [15:0] power_q;
	logic [ModeW-1:0]   mode_out_q;
	logic               dir_out_q;

	mdsd_shaper u_shaper (
		.cfg        (cfg),
		.request    (item_request),
		.last_power (last_q),
		.shaped     (shaped),
		.applied    (shaped_applied)
	);

	// The result register frees up when it is empty or its beat is taken.
	assign advance = !valid_q || out_ready;

	always_comb begin
		last_d    = last_q;
		applied_d = applied_q;
		mode_d    = mode_q;
		dir_d     = dir_q;
		latch_d   = latch_q;
		status_d  = 1'b0;
		case (item_command)
			CMD_SET: begin
				if (latch_q) begin
					status_d = 1'b1;
				end else begin
					last_d    = shaped;
					applied_d = shaped_applied;
					if (shaped_applied > 0) begin
						dir_d  = 1'b0;
						mode_d = MODE_RUN;
					end else if (shaped_applied < 0) begin
						dir_d  = 1'b1;
						mode_d = MODE_RUN;
					end else begin
						mode_d = MODE_IDLE;
					end
				end
			end
			CMD_STOP: begin
				last_d    = '0;
				applied_d = '0;
				mode_d    = MODE_IDLE;
			end
			CMD_ESTOP: begin
				last_d    = '0;
				applied_d = '0;
				mode_d    = MODE_ERROR;
				latch_d   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			applied_q <= '0;
			mode_q    <= MODE_IDLE;
			dir_q     <= 1'b0;
			latch_q   <= 1'b0;
			valid_q   <= 1'b0;
		end else if (advance) begin
			valid_q <= item_valid;
			if (item_valid) begin
				last_q    <= last_d;
				applied_q <= applied_d;
				mode_q    <= mode_d;
				dir_q     <= dir_d;
				latch_q   <= latch_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid) begin
			status_q   <= status_d;
			power_q    <= applied_d;
			mode_out_q <= mode_d;
			dir_out_q  <= dir_d;
		end
	end

	assign out_valid   = valid_q;
	assign status      = status_q;
	assign drive_power = power_q;
	assign run_state   = mode_out_q;
	assign heading     = dir_out_q;

endmodule

// File: src/motor_drive_slew_deadband_top.sv
// Motor drive command block: slew limiter with dead band and emergency latch.
//
// Each beat on the input channel is one command (set power, stop, emergency
// stop) and yields exactly one result beat carrying the status, the applied
// Q1.15 drive power, the run state and the heading. The block takes one
// command per clock cycle while results are taken: a command sits in the
// input register, where a single combinational pass (clamp to the power
// limit, slew limit against the previous command, dead band, optional
// inversion) runs against the stored drive state, and the result is then
// loaded into the result register, which drives the output.
// The drive state is updated in the same edge that loads the result, which
// lets the next command follow immediately. Both registers stall together
// when the result is not taken, so no beat is lost. A refused set power
// (emergency latched) reports status 1 and the unchanged state; the latch
// clears only on reset. Configuration writes take effect at once and are
// meant to happen only while no command is in flight.
module motor_drive_slew_deadband_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [14:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic signed [15:0]  power_request,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                status,
	output logic signed [15:0]  drive_power,
	output logic [1:0]          run_state,
	output logic                heading
);
	import mdsd_pkg::*;

	cfg_t cfg_q;

	logic               valid_s1;
	logic [CmdW-1:0]    command_s1;
	logic signed [15:0] request_s1;
	logic               advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_limit <= POWER_LIMIT_RST;
			cfg_q.slew_step   <= '0;
			cfg_q.dead_band   <= '0;
			cfg_q.invert_sign <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POWER_LIMIT: cfg_q.power_limit <= cfg_data;
				REG_SLEW_STEP:   cfg_q.slew_step   <= cfg_data;
				REG_DEAD_BAND:   cfg_q.dead_band   <= cfg_data;
				REG_INVERT_SIGN: cfg_q.invert_sign <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The input register moves on when it is empty or the result register can take
	// its beat, so a new command is accepted in the same cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			request_s1 <= power_request;
		end
	end

	mdsd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (valid_s1),
		.item_command (command_s1),
		.item_request (request_s1),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.drive_power  (drive_power),
		.run_state    (run_state),
		.heading      (heading)
	);

endmodule
